@@ rtl/core/slot_run_allocator_top_assert.svh @@
// Assertion macros shared by the allocator modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SLOT_RUN_ALLOCATOR_TOP_ASSERT_SVH
`define SLOT_RUN_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sra_pkg.sv @@
`default_nettype none

package sra_pkg;

  // Default number of slots, slot 0 included.
  localparam int SLOT_COUNT_DEF = 32;

  // Width of the slot and length fields in requests and results.
  localparam int FIELD_W = 5;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 5'd31;

  // Stream data widths, padded to whole bytes.
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  // Request operation codes.
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  // One request as seen by the slot table.
  typedef struct packed {
    func_t              func;
    logic [FIELD_W-1:0] alloc_size;
    logic [FIELD_W-1:0] free_start;
  } req_t;

  // Per-request outcome produced by the slot table.
  typedef struct packed {
    logic [FIELD_W-1:0] granted_slot;
    logic [FIELD_W-1:0] freed_length;
    logic               bad_free;
  } step_res_t;

endpackage

`default_nettype wire

@@ rtl/core/sra_slot_table.sv @@
`default_nettype none

module sra_slot_table #(
  parameter int SLOT_COUNT = sra_pkg::SLOT_COUNT_DEF
) (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         update_en,
  input  sra_pkg::req_t                               req,
  output sra_pkg::step_res_t                          res,
  output logic [SLOT_COUNT-1:0]                       slot_used,
  output logic [SLOT_COUNT-1:0][$clog2(SLOT_COUNT)-1:0] slot_len
);

  `include "slot_run_allocator_top_assert.svh"

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int LEN_W = IDX_W;
  // Wide enough for a slot index plus two run lengths, and for any 5-bit field.
  localparam int SUM_W = ((IDX_W > sra_pkg::FIELD_W) ? IDX_W : sra_pkg::FIELD_W) + 2;

  logic [SLOT_COUNT-1:0]            slot_used_next;
  logic [SLOT_COUNT-1:0][LEN_W-1:0] slot_len_next;

  logic [SUM_W-1:0]      size_ext;
  logic [SUM_W-1:0]      fs_ext;
  logic [SLOT_COUNT-1:0] fit;
  logic                  alloc_hit;
  logic [IDX_W-1:0]      alloc_idx;
  logic [LEN_W-1:0]      run_len;
  logic [SUM_W-1:0]      a_lo;
  logic [SUM_W-1:0]      a_mid;
  logic [SUM_W-1:0]      a_hi;
  logic [LEN_W-1:0]      a_len;
  logic [LEN_W-1:0]      rest_len;

  logic [IDX_W-1:0]      fs_idx;
  logic [IDX_W-1:0]      pm1_idx;
  logic                  free_ok;
  logic [LEN_W-1:0]      bsize;
  logic [LEN_W-1:0]      prev_raw;
  logic [LEN_W-1:0]      prev_len;
  logic [SUM_W-1:0]      nidx;
  logic                  nidx_in;
  logic [LEN_W-1:0]      next_len;
  logic [SUM_W-1:0]      f_start;
  logic [SUM_W-1:0]      f_end_raw;
  logic [SUM_W-1:0]      f_end;
  logic [LEN_W-1:0]      f_len;
  logic [SUM_W-1:0]      bsize_ext;
  logic [SUM_W-1:0]      freed_sat;

  // First-fit search: lowest free slot whose run holds the request.
  always_comb begin
    size_ext  = SUM_W'(req.alloc_size);
    alloc_idx = '0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      fit[j] = !slot_used[j] && (SUM_W'(slot_len[j]) >= size_ext);
    end
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (fit[j]) begin
        alloc_idx = IDX_W'(j);
      end
    end
    alloc_hit = (req.func == sra_pkg::FUNC_ALLOC) && (req.alloc_size != '0) && (|fit);
    run_len   = slot_len[alloc_idx];
    a_lo      = SUM_W'(alloc_idx);
    a_mid     = a_lo + size_ext;
    a_hi      = a_lo + SUM_W'(run_len);
    a_len     = size_ext[LEN_W-1:0];
    rest_len  = LEN_W'(SUM_W'(run_len) - size_ext);
  end

  // Free path: locate the block, its free neighbors and the merged span.
  always_comb begin
    fs_ext   = SUM_W'(req.free_start);
    fs_idx   = fs_ext[IDX_W-1:0];
    pm1_idx  = fs_idx - IDX_W'(1);
    free_ok  = (req.func == sra_pkg::FUNC_FREE) && (req.free_start != '0) &&
               (fs_ext < SUM_W'(SLOT_COUNT)) && slot_used[fs_idx];
    bsize    = slot_len[fs_idx];
    prev_raw = slot_used[pm1_idx] ? '0 : slot_len[pm1_idx];
    // A free run before the block cannot reach past slot 1.
    prev_len = (prev_raw > LEN_W'(pm1_idx)) ? LEN_W'(pm1_idx) : prev_raw;
    nidx     = fs_ext + SUM_W'(bsize);
    nidx_in  = nidx < SUM_W'(SLOT_COUNT);
    next_len = (nidx_in && !slot_used[nidx[IDX_W-1:0]]) ? slot_len[nidx[IDX_W-1:0]] : '0;
    f_start  = fs_ext - SUM_W'(prev_len);
    f_end_raw = fs_ext + SUM_W'(bsize) + SUM_W'(next_len);
    // The merged region stops at the last slot.
    f_end    = (f_end_raw > SUM_W'(SLOT_COUNT)) ? SUM_W'(SLOT_COUNT) : f_end_raw;
    f_len    = LEN_W'(f_end - f_start);
    bsize_ext = SUM_W'(bsize);
    freed_sat = (bsize_ext > SUM_W'(sra_pkg::FIELD_MAX)) ?
                SUM_W'(sra_pkg::FIELD_MAX) : bsize_ext;
  end

  // Repaint every slot in parallel.
  always_comb begin
    for (int j = 0; j < SLOT_COUNT; j++) begin
      slot_used_next[j] = slot_used[j];
      slot_len_next[j]  = slot_len[j];
      if (alloc_hit) begin
        if ((SUM_W'(j) >= a_lo) && (SUM_W'(j) < a_mid)) begin
          slot_used_next[j] = 1'b1;
          slot_len_next[j]  = a_len;
        end else if ((SUM_W'(j) >= a_mid) && (SUM_W'(j) < a_hi)) begin
          slot_used_next[j] = 1'b0;
          slot_len_next[j]  = rest_len;
        end
      end else if (free_ok) begin
        if ((SUM_W'(j) >= f_start) && (SUM_W'(j) < f_end)) begin
          slot_used_next[j] = 1'b0;
          slot_len_next[j]  = f_len;
        end
      end
    end
  end

  // Outcome of this request.
  always_comb begin
    res.granted_slot = alloc_hit ? a_lo[sra_pkg::FIELD_W-1:0] : '0;
    res.freed_length = free_ok ? freed_sat[sra_pkg::FIELD_W-1:0] : '0;
    res.bad_free     = (req.func == sra_pkg::FUNC_FREE) && !free_ok;
  end

  // Slot table storage; slot 0 is the sentinel and is never rewritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        slot_used[j] <= 1'b0;
        slot_len[j]  <= (j == 0) ? '0 : LEN_W'(SLOT_COUNT - 1);
      end
    end else if (update_en) begin
      slot_used <= slot_used_next;
      slot_len  <= slot_len_next;
    end
  end

  // Checks on the table logic.
  `SRA_ASSERT_NOW(a_sentinel_kept, 1'b1, !slot_used[0] && (slot_len[0] == '0),
    "slot 0 lost its sentinel value")
  `SRA_ASSERT_NOW(a_grant_xor_bad, 1'b1, !(res.bad_free && (res.granted_slot != '0)),
    "grant and bad free raised together")
  `SRA_ASSERT_NEXT(a_grant_marks_used, update_en && alloc_hit,
    slot_used[$past(alloc_idx)] && (slot_len[$past(alloc_idx)] == $past(a_len)),
    "granted slot not marked as allocated")

endmodule

`default_nettype wire

@@ rtl/core/sra_max_tree.sv @@
`default_nettype none

module sra_max_tree #(
  parameter int SLOT_COUNT = sra_pkg::SLOT_COUNT_DEF
) (
  input  wire  [SLOT_COUNT-1:0]                         slot_used,
  input  wire  [SLOT_COUNT-1:0][$clog2(SLOT_COUNT)-1:0] slot_len,
  output logic [sra_pkg::FIELD_W-1:0]                   largest_free
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int LEN_W  = IDX_W;
  localparam int LEAF_N = 2 ** IDX_W;
  localparam int EXT_W  = (LEN_W > sra_pkg::FIELD_W) ? LEN_W : sra_pkg::FIELD_W;

  logic [LEN_W-1:0] node [1:2*LEAF_N-1];
  logic [EXT_W-1:0] best_ext;

  // Leaves: free run lengths, allocated slots and padding count as zero.
  for (genvar k = 0; k < LEAF_N; k++) begin : g_leaf
    if (k < SLOT_COUNT) begin : g_real
      assign node[LEAF_N + k] = slot_used[k] ? '0 : slot_len[k];
    end else begin : g_pad
      assign node[LEAF_N + k] = '0;
    end
  end

  // Balanced compare tree, root at node 1.
  for (genvar k = 1; k < LEAF_N; k++) begin : g_node
    assign node[k] = (node[2*k] > node[2*k+1]) ? node[2*k] : node[2*k+1];
  end

  // Saturate to the field width.
  always_comb begin
    best_ext     = EXT_W'(node[1]);
    largest_free = (best_ext > EXT_W'(sra_pkg::FIELD_MAX)) ?
                   sra_pkg::FIELD_MAX : best_ext[sra_pkg::FIELD_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/slot_run_allocator_top.sv @@
// First-fit slot allocator over SLOT_COUNT slots (slot 0 is a reserved sentinel).
// Each request on the slave stream either allocates a run of alloc_size slots or
// frees the block starting at free_start, merging it with free neighbors. Every
// request yields exactly one result: the granted start slot (0 on failure), the
// freed length, the longest free run after the request, and a bad-free flag.
// The block accepts one request per clock while the master stream takes results. A
// request goes into the input register; the table is updated from it (first-fit
// search and repaint of all slots, combinational) as the middle register loads, and
// the largest-free compare tree then feeds the output register with the new table.
// Back-pressure on the master stream stalls the stages with no room ahead, including the slot
// table. Reset leaves every slot except slot 0 in one free run of SLOT_COUNT-1 slots.
`default_nettype none

module slot_run_allocator_top #(
  parameter int SLOT_COUNT = sra_pkg::SLOT_COUNT_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] alloc_size, [9:5] free_start, [15:10] zero
  input  wire  [sra_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  wire                            s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [4:0] granted_slot, [9:5] freed_length, [14:10] largest_free, [15] zero
  output logic [sra_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] bad_free
  output logic                           m_axis_tuser
);

  `include "slot_run_allocator_top_assert.svh"

  localparam int LEN_W = $clog2(SLOT_COUNT);

  logic                 in_valid;
  sra_pkg::req_t        in_req;
  logic                 mid_valid;
  sra_pkg::step_res_t   mid_res;
  logic                 out_valid;
  sra_pkg::step_res_t   out_res;
  logic [sra_pkg::FIELD_W-1:0] out_largest;

  sra_pkg::step_res_t   step_res;
  logic [sra_pkg::FIELD_W-1:0] largest_now;
  logic [SLOT_COUNT-1:0]            slot_used;
  logic [SLOT_COUNT-1:0][LEN_W-1:0] slot_len;

  logic en_out;
  logic en_mid;
  logic en_in;
  logic update_en;

  // Stage enables: a stage moves when the stage after it has room.
  always_comb begin
    en_out    = !out_valid || m_axis_tready;
    en_mid    = !mid_valid || en_out;
    en_in     = !in_valid || en_mid;
    update_en = in_valid && en_mid;
  end

  assign s_axis_tready = en_in;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_in) begin
        in_valid <= s_axis_tvalid;
      end
      if (en_mid) begin
        mid_valid <= in_valid;
      end
      if (en_out) begin
        out_valid <= mid_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (en_in && s_axis_tvalid) begin
      in_req.func       <= sra_pkg::func_t'(s_axis_tuser);
      in_req.alloc_size <= s_axis_tdata[4:0];
      in_req.free_start <= s_axis_tdata[9:5];
    end
    if (en_mid) begin
      mid_res <= step_res;
    end
    if (en_out) begin
      out_res     <= mid_res;
      out_largest <= largest_now;
    end
  end

  sra_slot_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .update_en (update_en),
    .req       (in_req),
    .res       (step_res),
    .slot_used (slot_used),
    .slot_len  (slot_len)
  );

  // The table already holds the state after the middle-stage request.
  sra_max_tree #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_max (
    .slot_used    (slot_used),
    .slot_len     (slot_len),
    .largest_free (largest_now)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_largest, out_res.freed_length, out_res.granted_slot};
  assign m_axis_tuser  = out_res.bad_free;

  // Pipeline checks.
  `SRA_ASSERT_NEXT(a_table_frozen_on_stall, mid_valid && !en_out,
    $stable(slot_used) && $stable(slot_len), "slot table changed while result stalled")
  `SRA_ASSERT_NEXT(a_update_reaches_mid, update_en, mid_valid,
    "table update without a request in the middle stage")
  `SRA_ASSERT_NEXT(a_result_held_on_stall, out_valid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while stalled")

endmodule

`default_nettype wire
